[hdl/lz4fd_pkg.sv]
`timescale 1ns / 1ps

package lz4fd_pkg;

   // field widths of the transfers
   localparam int BLOCK_LEN_BITS_DEF = 31;
   localparam int BLOCK_LEN_W        = 31;
   localparam int OFFSET_W           = 32;
   localparam int SIZE_W             = 32;

   // fixed region lengths in bytes
   localparam int MAGIC_LEN = 4;
   localparam int FLG_LEN   = 1;
   localparam int BD_LEN    = 1;
   localparam int CSIZE_LEN = 8;
   localparam int DICT_LEN  = 4;
   localparam int HSUM_LEN  = 1;
   localparam int BSUM_LEN  = 4;
   localparam int CSUM_LEN  = 4;

   // flag byte bit positions
   localparam int FLG_DICT_BIT  = 0;
   localparam int FLG_CSUM_BIT  = 2;
   localparam int FLG_CSIZE_BIT = 3;
   localparam int FLG_BSUM_BIT  = 4;
   localparam int FLG_INDEP_BIT = 5;

   // region codes as seen on the result channel
   localparam logic [3:0] REGION_MAGIC    = 4'd0;
   localparam logic [3:0] REGION_FLG      = 4'd1;
   localparam logic [3:0] REGION_BD       = 4'd2;
   localparam logic [3:0] REGION_CSIZE    = 4'd3;
   localparam logic [3:0] REGION_DICTID   = 4'd4;
   localparam logic [3:0] REGION_HDRSUM   = 4'd5;
   localparam logic [3:0] REGION_BLKSIZE  = 4'd6;
   localparam logic [3:0] REGION_DATA     = 4'd7;
   localparam logic [3:0] REGION_BLKSUM   = 4'd8;
   localparam logic [3:0] REGION_ENDMARK  = 4'd9;
   localparam logic [3:0] REGION_CSUM     = 4'd10;
   localparam logic [3:0] REGION_TRAILING = 4'd11;

   // parser phase, one-hot
   typedef enum logic [11:0] {
      PH_MAGIC = 12'b0000_0000_0001,
      PH_FLG   = 12'b0000_0000_0010,
      PH_BD    = 12'b0000_0000_0100,
      PH_CSIZE = 12'b0000_0000_1000,
      PH_DICT  = 12'b0000_0001_0000,
      PH_HSUM  = 12'b0000_0010_0000,
      PH_BSIZE = 12'b0000_0100_0000,
      PH_DATA  = 12'b0000_1000_0000,
      PH_BSUM  = 12'b0001_0000_0000,
      PH_END   = 12'b0010_0000_0000,
      PH_CSUM  = 12'b0100_0000_0000,
      PH_TRAIL = 12'b1000_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [3:0]             region;
      logic                   region_last;
      logic                   block_stored;
      logic [BLOCK_LEN_W-1:0] block_length;
      logic [OFFSET_W-1:0]    frame_offset;
      logic                   block_sum_on;
      logic                   content_sum_on;
      logic                   content_size_on;
      logic                   dict_id_on;
      logic                   blocks_independent;
      logic [1:0]             format_version;
      logic [2:0]             max_block_code;
   } rsp_type;

endpackage

[hdl/lz4fd_core.sv]
`timescale 1ns / 1ps

module lz4fd_core #(
   parameter int BLOCK_LEN_BITS = lz4fd_pkg::BLOCK_LEN_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  lz4fd_pkg::req_type req,
   output lz4fd_pkg::rsp_type rsp
);
   import lz4fd_pkg::*;

   localparam int CNT_W = BLOCK_LEN_BITS;
   localparam int CW    = BLOCK_LEN_BITS + 1;

   phase_type                 phase_ff, phase_in, cur_phase, fix_next;
   logic [CNT_W-1:0]          count_ff, count_in, cur_count;
   logic [SIZE_W-1:0]         accum_ff, accum_in, cur_accum;
   logic [7:0]                flag_ff, flag_in, cur_flag;
   logic [2:0]                maxc_ff, maxc_in, cur_maxc;
   logic [OFFSET_W-1:0]       offset_ff, offset_in, cur_offset;
   logic                      stored_ff, stored_in, cur_stored;
   logic [CW-1:0]             cnt_inc, fix_n;
   logic                      fix_en;
   logic [1:0]                idx;
   logic [3:0]                region;
   logic                      last, show;

   // parser step for one byte
   always_comb begin
      // frame start restarts from the reset state
      cur_phase  = phase_ff;
      cur_count  = count_ff;
      cur_accum  = accum_ff;
      cur_flag   = flag_ff;
      cur_maxc   = maxc_ff;
      cur_offset = offset_ff;
      cur_stored = stored_ff;
      if (req.frame_start) begin
         cur_phase  = PH_MAGIC;
         cur_count  = '0;
         cur_accum  = '0;
         cur_flag   = '0;
         cur_maxc   = '0;
         cur_offset = '0;
         cur_stored = 1'b0;
      end

      phase_in  = cur_phase;
      count_in  = cur_count;
      accum_in  = cur_accum;
      flag_in   = cur_flag;
      maxc_in   = cur_maxc;
      stored_in = cur_stored;
      offset_in = (&cur_offset) ? cur_offset : cur_offset + OFFSET_W'(1);

      cnt_inc  = {1'b0, cur_count} + CW'(1);
      idx      = cur_count[1:0];
      fix_en   = 1'b0;
      fix_n    = CW'(1);
      fix_next = PH_TRAIL;
      region   = REGION_TRAILING;
      last     = 1'b0;
      show     = 1'b1;

      unique case (cur_phase)
         PH_MAGIC: begin
            region   = REGION_MAGIC;
            fix_en   = 1'b1;
            fix_n    = CW'(MAGIC_LEN);
            fix_next = PH_FLG;
         end
         PH_FLG: begin
            region   = REGION_FLG;
            flag_in  = req.data_byte;
            fix_en   = 1'b1;
            fix_n    = CW'(FLG_LEN);
            fix_next = PH_BD;
         end
         PH_BD: begin
            region   = REGION_BD;
            maxc_in  = req.data_byte[6:4];
            fix_en   = 1'b1;
            fix_n    = CW'(BD_LEN);
            if (cur_flag[FLG_CSIZE_BIT]) begin
               fix_next = PH_CSIZE;
            end else if (cur_flag[FLG_DICT_BIT]) begin
               fix_next = PH_DICT;
            end else begin
               fix_next = PH_HSUM;
            end
         end
         PH_CSIZE: begin
            region   = REGION_CSIZE;
            fix_en   = 1'b1;
            fix_n    = CW'(CSIZE_LEN);
            fix_next = cur_flag[FLG_DICT_BIT] ? PH_DICT : PH_HSUM;
         end
         PH_DICT: begin
            region   = REGION_DICTID;
            fix_en   = 1'b1;
            fix_n    = CW'(DICT_LEN);
            fix_next = PH_HSUM;
         end
         PH_HSUM: begin
            region   = REGION_HDRSUM;
            fix_en   = 1'b1;
            fix_n    = CW'(HSUM_LEN);
            fix_next = PH_BSIZE;
         end
         PH_BSIZE: begin
            region = REGION_BLKSIZE;
            // gather the little-endian size word
            case (idx)
               2'd0:    accum_in = {24'b0, req.data_byte};
               2'd1:    accum_in = cur_accum | {16'b0, req.data_byte, 8'b0};
               2'd2:    accum_in = cur_accum | {8'b0, req.data_byte, 16'b0};
               default: accum_in = cur_accum | {req.data_byte, 24'b0};
            endcase
            if (idx == 2'd3) begin
               last      = 1'b1;
               count_in  = '0;
               stored_in = accum_in[SIZE_W-1];
               if (accum_in == '0) begin
                  region   = REGION_ENDMARK;
                  phase_in = cur_flag[FLG_CSUM_BIT] ? PH_CSUM : PH_TRAIL;
               end else if (|accum_in[BLOCK_LEN_BITS-1:0]) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = cur_flag[FLG_BSUM_BIT] ? PH_BSUM : PH_BSIZE;
               end
            end else begin
               count_in = CNT_W'(idx) + CNT_W'(1);
               show     = 1'b0;
            end
         end
         PH_DATA: begin
            region   = REGION_DATA;
            fix_en   = 1'b1;
            fix_n    = {1'b0, cur_accum[BLOCK_LEN_BITS-1:0]};
            fix_next = cur_flag[FLG_BSUM_BIT] ? PH_BSUM : PH_BSIZE;
         end
         PH_BSUM: begin
            region   = REGION_BLKSUM;
            fix_en   = 1'b1;
            fix_n    = CW'(BSUM_LEN);
            fix_next = PH_BSIZE;
         end
         PH_CSUM: begin
            region   = REGION_CSUM;
            fix_en   = 1'b1;
            fix_n    = CW'(CSUM_LEN);
            fix_next = PH_TRAIL;
         end
         default: begin
            // trailing bytes and any stray phase
            region   = REGION_TRAILING;
            phase_in = PH_TRAIL;
            count_in = '0;
         end
      endcase

      // walk through a fixed-length region
      if (fix_en) begin
         if (cnt_inc >= fix_n) begin
            last     = 1'b1;
            count_in = '0;
            phase_in = fix_next;
         end else begin
            count_in = cnt_inc[CNT_W-1:0];
         end
      end

      rsp.region             = region;
      rsp.region_last        = last;
      rsp.block_stored       = show ? stored_in : 1'b0;
      rsp.block_length       = show ? BLOCK_LEN_W'(accum_in[BLOCK_LEN_BITS-1:0])
                                    : '0;
      rsp.frame_offset       = cur_offset;
      rsp.block_sum_on       = flag_in[FLG_BSUM_BIT];
      rsp.content_sum_on     = flag_in[FLG_CSUM_BIT];
      rsp.content_size_on    = flag_in[FLG_CSIZE_BIT];
      rsp.dict_id_on         = flag_in[FLG_DICT_BIT];
      rsp.blocks_independent = flag_in[FLG_INDEP_BIT];
      rsp.format_version     = flag_in[7:6];
      rsp.max_block_code     = maxc_in;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         count_ff  <= '0;
         accum_ff  <= '0;
         flag_ff   <= '0;
         maxc_ff   <= '0;
         offset_ff <= '0;
         stored_ff <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         accum_ff  <= accum_in;
         flag_ff   <= flag_in;
         maxc_ff   <= maxc_in;
         offset_ff <= offset_in;
         stored_ff <= stored_in;
      end
   end

endmodule

[hdl/lz4_frame_deframer.sv]
`timescale 1ns / 1ps

// LZ4 frame deframer: takes one frame byte per transfer and returns one tagged
// result per byte, naming the frame region of that byte, whether it ends the
// region, the decoded FLG/BD fields, the current block length and stored bit,
// and the saturating byte offset in the frame. A byte with frame_start set
// restarts the parser as the first magic byte. One byte is taken every cycle
// while req_stall is low; a byte passes the input register, then the parser
// step into the result register, from which its result is offered. While the
// result register waits on rsp_stall one more byte is held in the input
// register, after which req_stall rises. No value checks are made on magic,
// version or checksums.
module lz4_frame_deframer #(
   parameter int BLOCK_LEN_BITS = lz4fd_pkg::BLOCK_LEN_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lz4fd_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lz4fd_pkg::rsp_type rsp_payload
);
   import lz4fd_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_rsp;
   logic    advance;
   logic    req_take;

   // flow control between the input and result registers
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   lz4fd_core #(
      .BLOCK_LEN_BITS(BLOCK_LEN_BITS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .step (advance),
      .req  (in_data_ff),
      .rsp  (step_rsp)
   );

   // handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_payload;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

`ifndef ASSERT_OFF
   // a held input byte is never dropped
   a_in_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input byte lost while waiting");

   // every parser step lands in the result register
   a_step_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("parser step without result");

   // the end mark always closes its region
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.region == REGION_ENDMARK |-> rsp_payload.region_last)
      else $error("end mark without region_last");

   // partial size words show no length
   a_partial_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.region == REGION_BLKSIZE && !rsp_payload.region_last
      |-> rsp_payload.block_length == '0 && !rsp_payload.block_stored)
      else $error("length shown before size word complete");

   // header regions carry no block information
   a_hdr_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.region == REGION_MAGIC
                    || rsp_payload.region == REGION_FLG
                    || rsp_payload.region == REGION_BD
                    || rsp_payload.region == REGION_CSIZE
                    || rsp_payload.region == REGION_DICTID
                    || rsp_payload.region == REGION_HDRSUM)
      |-> rsp_payload.block_length == '0 && !rsp_payload.block_stored)
      else $error("block length in header region");
`endif

endmodule
